@@ rtl/rse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg
// Shared constants and GF(2^8) arithmetic for the Reed-Solomon ECC encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int          MAX_DEGREE_DEF = 30;
  localparam int          LEN_W          = 5;
  localparam int          BYTE_W         = 8;
  localparam int          CFG_DATA_W     = 32;
  localparam int          CFG_ADDR_W     = 3;
  localparam logic [8:0]  GF_POLY        = 9'h11D;
  localparam logic [7:0]  GF_ALPHA       = 8'h02;
  localparam logic [LEN_W-1:0] ECC_LENGTH_RESET = 5'd7;

  // Register index taken from the word address.
  localparam logic        REG_ECC_LENGTH = 1'b0;

  typedef logic [BYTE_W-1:0] gf_byte_t;

  // Multiply by x modulo the field polynomial.
  function automatic gf_byte_t gf_xtime(input gf_byte_t a);
    gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY[7:0] : 8'h00);
  endfunction

  // Shift-and-add multiply over GF(2^8).
  function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
    gf_byte_t acc;
    gf_byte_t x;
    acc = '0;
    x   = a;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) acc = acc ^ x;
      x = gf_xtime(x);
    end
    gf_mul = acc;
  endfunction

endpackage
`default_nettype wire

@@ rtl/reed_solomon_ecc_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reed_solomon_ecc_encoder
// Systematic Reed-Solomon ECC encoder over GF(2^8), polynomial 0x11D.
// ----------------------------------------------------------------------------
// Message bytes enter on the in_ channel at one byte per cycle while in_tready
// is high; each byte goes through an input register and then one LFSR step
// that multiplies all generator coefficients by a single factor in parallel.
// The byte marked last hands the n-byte remainder to an output buffer that
// drains one ECC byte per cycle while out_tready is high, highest power first,
// with tlast on the final one. A last byte waits in the input register while
// the buffer still drains the previous block's ECC bytes, so a block of n
// bytes or fewer costs extra cycles. After reset and after each write of
// ecc_length the generator is rebuilt, one root per cycle, while in_tready is
// low (n is ecc_length clamped to 1..MAX_DEGREE). Write ecc_length only while
// the block is idle; the write also clears the running remainder.
// ----------------------------------------------------------------------------
module reed_solomon_ecc_encoder
  import rse_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // in_tdata: [7:0] data_byte
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [7:0]            in_tdata,
  input  wire                   in_tlast,
  // out_tdata: [7:0] ecc_byte
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast,
  input  wire                   cfg_psel,
  input  wire                   cfg_penable,
  input  wire                   cfg_pwrite,
  input  wire  [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire  [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int DW = $clog2(MAX_DEGREE + 1);

  function automatic logic [DW-1:0] clamp_deg(input logic [LEN_W-1:0] len);
    logic [DW-1:0] d;
    if (len == '0) begin
      d = DW'(1);
    end else if (int'(len) > MAX_DEGREE) begin
      d = DW'(MAX_DEGREE);
    end else begin
      d = DW'(len);
    end
    clamp_deg = d;
  endfunction

  // Configuration.
  logic [LEN_W-1:0] ecc_length_r;
  logic [DW-1:0]    deg_r;
  logic             cfg_wr;

  // Generator build.
  logic             start_r;
  logic [DW-1:0]    gen_cnt_r;
  gf_byte_t         root_r;
  gf_byte_t         gen_r   [MAX_DEGREE];
  gf_byte_t         gen_nxt [MAX_DEGREE];
  logic             gen_busy;

  // Input register and LFSR.
  logic             in_valid_r;
  gf_byte_t         in_data_r;
  logic             in_last_r;
  logic             advance;
  gf_byte_t         factor;
  gf_byte_t         rem_r   [MAX_DEGREE];
  gf_byte_t         rem_nxt [MAX_DEGREE];

  // Output buffer.
  gf_byte_t         obuf_r  [MAX_DEGREE];
  logic [DW-1:0]    out_cnt_r;
  logic             out_busy;
  logic             out_fire;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                      & (cfg_paddr[2] == REG_ECC_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == REG_ECC_LENGTH)
                      ? CFG_DATA_W'(ecc_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecc_length_r <= ECC_LENGTH_RESET;
      deg_r        <= clamp_deg(ECC_LENGTH_RESET);
    end else if (cfg_wr) begin
      ecc_length_r <= cfg_pwdata[LEN_W-1:0];
      deg_r        <= clamp_deg(cfg_pwdata[LEN_W-1:0]);
    end
  end

  assign gen_busy = start_r | (gen_cnt_r != '0);

  // One build step multiplies the generator by (x - root).
  always_comb begin
    for (int j = 0; j < MAX_DEGREE - 1; j++) begin
      gen_nxt[j] = gf_mul(gen_r[j], root_r) ^ gen_r[j+1];
    end
    gen_nxt[MAX_DEGREE-1] = gf_mul(gen_r[MAX_DEGREE-1], root_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= 1'b1;
      gen_cnt_r <= '0;
    end else if (cfg_wr) begin
      start_r   <= 1'b1;
      gen_cnt_r <= '0;
    end else if (start_r) begin
      start_r   <= 1'b0;
      gen_cnt_r <= deg_r;
    end else if (gen_cnt_r != '0) begin
      gen_cnt_r <= gen_cnt_r - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      root_r <= 8'h01;
      for (int j = 0; j < MAX_DEGREE; j++) begin
        gen_r[j] <= (int'(deg_r) - 1 == j) ? 8'h01 : 8'h00;
      end
    end else if (gen_cnt_r != '0) begin
      root_r <= gf_mul(root_r, GF_ALPHA);
      for (int j = 0; j < MAX_DEGREE; j++) begin
        gen_r[j] <= gen_nxt[j];
      end
    end
  end

  // A last item holds in the input register until the output buffer is free.
  assign out_busy  = (out_cnt_r != '0);
  assign advance   = in_valid_r & ~(in_last_r & out_busy);
  assign in_tready = ~gen_busy & (~in_valid_r | advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Entries at and above the degree stay zero, so the shift needs no mask.
  assign factor = in_data_r ^ rem_r[0];

  always_comb begin
    for (int j = 0; j < MAX_DEGREE - 1; j++) begin
      rem_nxt[j] = rem_r[j+1] ^ gf_mul(gen_r[j], factor);
    end
    rem_nxt[MAX_DEGREE-1] = gf_mul(gen_r[MAX_DEGREE-1], factor);
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      for (int j = 0; j < MAX_DEGREE; j++) begin
        rem_r[j] <= 8'h00;
      end
    end else if (advance) begin
      for (int j = 0; j < MAX_DEGREE; j++) begin
        rem_r[j] <= in_last_r ? 8'h00 : rem_nxt[j];
      end
    end
  end

  assign out_fire = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cnt_r <= '0;
    end else if (advance && in_last_r) begin
      out_cnt_r <= deg_r;
    end else if (out_fire) begin
      out_cnt_r <= out_cnt_r - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      for (int j = 0; j < MAX_DEGREE; j++) begin
        obuf_r[j] <= rem_nxt[j];
      end
    end else if (out_fire) begin
      for (int j = 0; j < MAX_DEGREE - 1; j++) begin
        obuf_r[j] <= obuf_r[j+1];
      end
      obuf_r[MAX_DEGREE-1] <= 8'h00;
    end
  end

  assign out_tvalid = out_busy;
  assign out_tdata  = obuf_r[0];
  assign out_tlast  = (out_cnt_r == DW'(1));

  // No item may enter while the generator is being rebuilt.
  a_no_accept_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    gen_busy |-> !in_tready)
    else $error("input accepted during generator build");

  // A finished block loads exactly n ECC bytes into the output buffer.
  a_block_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |=> (out_cnt_r == $past(deg_r)))
    else $error("ECC byte count does not match degree");

  // The drain count never runs past the configured degree.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_busy |-> (out_cnt_r <= deg_r))
    else $error("ECC drain count exceeds degree");

endmodule
`default_nettype wire
